// File: hw/rtl/mmfcq_pkg.sv
// shared constants, payload types and helper functions of the false color quantizer
`timescale 1ns / 1ps
`default_nettype none

package mmfcq_pkg;

   // image geometry and color levels
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int MAX_MAG  = 8;
   localparam int LEVELS   = 40;

   // fixed field widths
   localparam int SAMPLE_W    = 24;
   localparam int DIM_CFG_W   = 7;
   localparam int RANGE_CFG_W = 7;
   localparam int MAG_CFG_W   = 4;
   localparam int CHAR_W      = 8;

   // derived widths
   localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int REP_W       = (MAX_MAG > 1) ? $clog2(MAX_MAG) : 1;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

   // scaling arithmetic
   localparam int PCT_FULL = 100;
   localparam int SCALE_W  = SAMPLE_W + RANGE_CFG_W;
   localparam int NUM_W    = SCALE_W + 1;
   localparam int QUO_W    = $clog2(LEVELS + 1);
   localparam int REM_W    = SCALE_W + QUO_W;
   localparam int STEP_W   = (QUO_W > 1) ? $clog2(QUO_W) : 1;

   // codes
   localparam logic signed [SAMPLE_W-1:0] TRANSPARENT_CODE = -24'sd100000;
   localparam logic [CHAR_W-1:0] CHAR_TRANSPARENT = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_BASE        = 8'd100;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   // register indexes, byte address is four times the index
   typedef enum logic [1:0] {
      REG_ROWS  = 2'd0,
      REG_COLS  = 2'd1,
      REG_RANGE = 2'd2,
      REG_MAG   = 2'd3
   } reg_index_type;

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] pixel_char;
      logic              last_of_run;
      logic              end_of_line;
      logic              end_of_image;
   } rsp_type;

   // clamped configuration seen by front and back
   typedef struct packed {
      logic [DIM_CFG_W-1:0]   rows;
      logic [DIM_CFG_W-1:0]   cols;
      logic [RANGE_CFG_W-1:0] range_pct;
      logic [MAG_CFG_W-1:0]   mag;
   } cfg_type;

   // one display pixel handed from front to back
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] pixel_value;
      logic signed [SAMPLE_W-1:0] max_val;
      logic signed [SAMPLE_W-1:0] min_val;
      logic                       end_of_line;
      logic                       end_of_image;
   } cmd_type;

   function automatic logic [DIM_CFG_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v,
                                                      input logic [DIM_CFG_W-1:0] hi);
      logic [DIM_CFG_W-1:0] r;
      if (v == '0) begin
         r = DIM_CFG_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [MAG_CFG_W-1:0] clamp_mag(input logic [MAG_CFG_W-1:0] v);
      logic [MAG_CFG_W-1:0] r;
      if (v == '0) begin
         r = MAG_CFG_W'(1);
      end else if (v > MAG_CFG_W'(MAX_MAG)) begin
         r = MAG_CFG_W'(MAX_MAG);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [RANGE_CFG_W-1:0] clamp_range(input logic [RANGE_CFG_W-1:0] v);
      logic [RANGE_CFG_W-1:0] r;
      if (v > RANGE_CFG_W'(PCT_FULL)) begin
         r = RANGE_CFG_W'(PCT_FULL);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] level_char(input logic [QUO_W-1:0] quo);
      logic [QUO_W-1:0] lvl;
      if (quo > QUO_W'(LEVELS - 1)) begin
         lvl = QUO_W'(LEVELS - 1);
      end else begin
         lvl = quo;
      end
      return CHAR_BASE + CHAR_W'(lvl);
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mmfcq_front.sv
// front part: takes loads and emit requests, keeps the image, min/max and display walk
`timescale 1ns / 1ps
`default_nettype none

module mmfcq_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire mmfcq_pkg::req_type req_data,
   input  wire mmfcq_pkg::cfg_type cfg,
   output logic                   q_push,
   output mmfcq_pkg::cmd_type     q_data,
   input  wire logic              q_full
);

   logic signed [mmfcq_pkg::SAMPLE_W-1:0] image_mem [mmfcq_pkg::STORE_DEPTH];

   logic [mmfcq_pkg::COUNT_W-1:0]         load_count_ff, load_count_in;
   logic                                  emitting_ff, emitting_in;
   logic signed [mmfcq_pkg::SAMPLE_W-1:0] max_ff, max_in;
   logic signed [mmfcq_pkg::SAMPLE_W-1:0] min_ff, min_in;
   logic [mmfcq_pkg::ROW_W-1:0]           row_ff, row_in;
   logic [mmfcq_pkg::REP_W-1:0]           rep_ff, rep_in;
   logic [mmfcq_pkg::COL_W-1:0]           col_ff, col_in;

   logic                                  p1_valid_ff, p1_valid_in;
   logic signed [mmfcq_pkg::SAMPLE_W-1:0] pix_rd_ff;
   logic signed [mmfcq_pkg::SAMPLE_W-1:0] p1_max_ff, p1_min_ff;
   logic                                  p1_eol_ff, p1_eoi_ff;

   logic                          accept, is_load, is_emit, full_img;
   logic                          do_load, do_emit;
   logic [mmfcq_pkg::COUNT_W-1:0] total, idx_wide;
   logic [mmfcq_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
   logic                          eol, last_rep, last_row, eoi;

   assign req_full = p1_valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign is_load  = req_data.op == mmfcq_pkg::OP_LOAD;
   assign is_emit  = req_data.op == mmfcq_pkg::OP_EMIT;

   assign total    = mmfcq_pkg::COUNT_W'(cfg.rows) * mmfcq_pkg::COUNT_W'(cfg.cols);
   assign full_img = load_count_ff >= total;
   assign do_load  = accept && is_load && !emitting_ff && !full_img;
   assign do_emit  = accept && is_emit && (emitting_ff || full_img);

   // display walk position and its limits
   assign idx_wide = mmfcq_pkg::COUNT_W'(row_ff) * mmfcq_pkg::COUNT_W'(cfg.cols)
                   + mmfcq_pkg::COUNT_W'(col_ff);
   assign rd_addr  = idx_wide[mmfcq_pkg::ADDR_W-1:0];
   assign wr_addr  = load_count_ff[mmfcq_pkg::ADDR_W-1:0];
   assign eol      = (mmfcq_pkg::DIM_CFG_W'(col_ff) + mmfcq_pkg::DIM_CFG_W'(1)) >= cfg.cols;
   assign last_row = (mmfcq_pkg::DIM_CFG_W'(row_ff) + mmfcq_pkg::DIM_CFG_W'(1)) >= cfg.rows;
   assign last_rep = (mmfcq_pkg::MAG_CFG_W'(rep_ff) + mmfcq_pkg::MAG_CFG_W'(1)) >= cfg.mag;
   assign eoi      = eol && last_rep && last_row;

   always_comb begin
      load_count_in = load_count_ff;
      emitting_in   = emitting_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      row_in        = row_ff;
      rep_in        = rep_ff;
      col_in        = col_ff;

      if (do_load) begin
         if (req_data.pixel_value != mmfcq_pkg::TRANSPARENT_CODE) begin
            if (req_data.pixel_value > max_ff) begin
               max_in = req_data.pixel_value;
            end
            if (req_data.pixel_value < min_ff) begin
               min_in = req_data.pixel_value;
            end
         end
         load_count_in = load_count_ff + mmfcq_pkg::COUNT_W'(1);
         if (load_count_in >= total) begin
            emitting_in = 1'b1;
         end
      end

      // any item seen with the image already complete opens emission
      if (accept && !emitting_ff && full_img) begin
         emitting_in = 1'b1;
      end

      if (do_emit) begin
         if (eoi) begin
            load_count_in = '0;
            emitting_in   = 1'b0;
            max_in        = '0;
            min_in        = '0;
            row_in        = '0;
            rep_in        = '0;
            col_in        = '0;
         end else if (eol) begin
            col_in = '0;
            if (last_rep) begin
               rep_in = '0;
               row_in = row_ff + mmfcq_pkg::ROW_W'(1);
            end else begin
               rep_in = rep_ff + mmfcq_pkg::REP_W'(1);
            end
         end else begin
            col_in = col_ff + mmfcq_pkg::COL_W'(1);
         end
      end
   end

   // stage one holds until the queue takes it
   assign p1_valid_in = do_emit || (p1_valid_ff && q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         emitting_ff   <= 1'b0;
         max_ff        <= '0;
         min_ff        <= '0;
         row_ff        <= '0;
         rep_ff        <= '0;
         col_ff        <= '0;
         p1_valid_ff   <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         emitting_ff   <= emitting_in;
         max_ff        <= max_in;
         min_ff        <= min_in;
         row_ff        <= row_in;
         rep_ff        <= rep_in;
         col_ff        <= col_in;
         p1_valid_ff   <= p1_valid_in;
      end
   end

   // image store, one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (do_load) begin
         image_mem[wr_addr] <= req_data.pixel_value;
      end
      if (do_emit) begin
         pix_rd_ff <= image_mem[rd_addr];
      end
   end

   // min/max snapshot travels with the pixel so a restart cannot disturb it
   always_ff @(posedge clock) begin
      if (do_emit) begin
         p1_max_ff <= max_ff;
         p1_min_ff <= min_ff;
         p1_eol_ff <= eol;
         p1_eoi_ff <= eoi;
      end
   end

   assign q_push = p1_valid_ff;
   assign q_data = '{pixel_value:  pix_rd_ff,
                     max_val:      p1_max_ff,
                     min_val:      p1_min_ff,
                     end_of_line:  p1_eol_ff,
                     end_of_image: p1_eoi_ff};

endmodule

`default_nettype wire

// File: hw/rtl/mmfcq_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module mmfcq_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire mmfcq_pkg::cmd_type push_data,
   input  wire logic              pop,
   output logic                   empty,
   output mmfcq_pkg::cmd_type     pop_data
);

   mmfcq_pkg::cmd_type              slot_ff [mmfcq_pkg::Q_DEPTH];
   logic [mmfcq_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mmfcq_pkg::Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mmfcq_pkg::Q_CNT_W-1:0]   count_ff, count_in;
   logic                            push_ok, pop_ok;

   assign full     = count_ff == mmfcq_pkg::Q_CNT_W'(mmfcq_pkg::Q_DEPTH);
   assign empty    = count_ff == '0;
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == mmfcq_pkg::Q_PTR_W'(mmfcq_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mmfcq_pkg::Q_PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == mmfcq_pkg::Q_PTR_W'(mmfcq_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mmfcq_pkg::Q_PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + mmfcq_pkg::Q_CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - mmfcq_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   ast_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mmfcq_pkg::Q_CNT_W'(mmfcq_pkg::Q_DEPTH))
      else $error("queue count past depth");

endmodule

`default_nettype wire

// File: hw/rtl/mmfcq_back.sv
// back part: scales a pixel, divides out its color level and replicates the beat
`timescale 1ns / 1ps
`default_nettype none

module mmfcq_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire mmfcq_pkg::cmd_type q_data,
   output logic                   q_pop,
   input  wire mmfcq_pkg::cfg_type cfg,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output mmfcq_pkg::rsp_type     rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCALE  = 6'b000010,
      ST_OFFSET = 6'b000100,
      ST_PREP   = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_SEND   = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;

   mmfcq_pkg::cmd_type                   cmd_ff, cmd_in;
   logic signed [mmfcq_pkg::SCALE_W-1:0] top_ff, top_in;
   logic signed [mmfcq_pkg::SCALE_W-1:0] v100_ff, v100_in;
   logic signed [mmfcq_pkg::SCALE_W-1:0] min100_ff, min100_in;
   logic [mmfcq_pkg::SCALE_W-1:0]        num_ff, num_in;
   logic [mmfcq_pkg::SCALE_W-1:0]        den_ff, den_in;
   logic [mmfcq_pkg::REM_W-1:0]          rem_ff, rem_in;
   logic [mmfcq_pkg::REM_W-1:0]          dsr_ff, dsr_in;
   logic [mmfcq_pkg::QUO_W-1:0]          quo_ff, quo_in;
   logic [mmfcq_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [mmfcq_pkg::CHAR_W-1:0]         char_ff, char_in;
   logic [mmfcq_pkg::REP_W-1:0]          beat_ff, beat_in;
   logic                                 out_valid_ff, out_valid_in;
   mmfcq_pkg::rsp_type                   out_ff, out_in;

   logic signed [mmfcq_pkg::SCALE_W-1:0] sel;
   logic signed [mmfcq_pkg::NUM_W-1:0]   num_s, den_s;
   logic                                 ge, beat_last;

   // clipped sample less offset, and full span
   assign sel   = (v100_ff > top_ff) ? top_ff : v100_ff;
   assign num_s = mmfcq_pkg::NUM_W'(sel) - mmfcq_pkg::NUM_W'(min100_ff);
   assign den_s = mmfcq_pkg::NUM_W'(top_ff) - mmfcq_pkg::NUM_W'(min100_ff);

   assign ge        = rem_ff >= dsr_ff;
   assign beat_last = (mmfcq_pkg::MAG_CFG_W'(beat_ff) + mmfcq_pkg::MAG_CFG_W'(1)) == cfg.mag;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      top_in       = top_ff;
      v100_in      = v100_ff;
      min100_in    = min100_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      char_in      = char_ff;
      beat_in      = beat_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            top_in    = mmfcq_pkg::SCALE_W'(cmd_ff.max_val)
                      * mmfcq_pkg::SCALE_W'(cfg.range_pct);
            v100_in   = mmfcq_pkg::SCALE_W'(cmd_ff.pixel_value)
                      * mmfcq_pkg::SCALE_W'(mmfcq_pkg::PCT_FULL);
            min100_in = mmfcq_pkg::SCALE_W'(cmd_ff.min_val)
                      * mmfcq_pkg::SCALE_W'(mmfcq_pkg::PCT_FULL);
            state_in  = ST_OFFSET;
         end
         ST_OFFSET: begin
            num_in = num_s[mmfcq_pkg::SCALE_W-1:0];
            den_in = den_s[mmfcq_pkg::SCALE_W-1:0];
            if (cmd_ff.pixel_value == mmfcq_pkg::TRANSPARENT_CODE) begin
               char_in  = mmfcq_pkg::CHAR_TRANSPARENT;
               state_in = ST_SEND;
            end else if (num_s[mmfcq_pkg::NUM_W-1] || num_s == '0) begin
               // at or below the minimum, also covers an empty span
               char_in  = mmfcq_pkg::CHAR_BASE;
               state_in = ST_SEND;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rem_in   = mmfcq_pkg::REM_W'(num_ff) * mmfcq_pkg::REM_W'(mmfcq_pkg::LEVELS);
            dsr_in   = mmfcq_pkg::REM_W'(den_ff) << (mmfcq_pkg::QUO_W - 1);
            quo_in   = '0;
            step_in  = mmfcq_pkg::STEP_W'(mmfcq_pkg::QUO_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dsr_ff;
            end
            quo_in  = {quo_ff[mmfcq_pkg::QUO_W-2:0], ge};
            dsr_in  = dsr_ff >> 1;
            step_in = step_ff - mmfcq_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               char_in  = mmfcq_pkg::level_char(quo_in);
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_in       = '{pixel_char:   char_ff,
                                last_of_run:  beat_last,
                                end_of_line:  beat_last && cmd_ff.end_of_line,
                                end_of_image: beat_last && cmd_ff.end_of_image};
               if (beat_last) begin
                  beat_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  beat_in = beat_ff + mmfcq_pkg::REP_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         beat_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beat_ff      <= beat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      top_ff    <= top_in;
      v100_ff   <= v100_in;
      min100_ff <= min100_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      dsr_ff    <= dsr_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      char_ff   <= char_in;
      out_ff    <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   ast_div_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("division started with zero span");

   ast_eoi_closes_line: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.end_of_image) |->
      (out_ff.end_of_line && out_ff.last_of_run))
      else $error("image end without line end");

   ast_char_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.pixel_char != mmfcq_pkg::CHAR_TRANSPARENT) |->
      (out_ff.pixel_char >= mmfcq_pkg::CHAR_BASE &&
       out_ff.pixel_char <= mmfcq_pkg::CHAR_BASE
                          + mmfcq_pkg::CHAR_W'(mmfcq_pkg::LEVELS - 1)))
      else $error("color character out of range");

endmodule

`default_nettype wire

// File: hw/rtl/minmax_false_color_quantizer.sv
// top level of the min/max normalizing false color quantizer with its register port
`timescale 1ns / 1ps
`default_nettype none

//  channel  | direction | handshake                   | beat
//  ---------+-----------+-----------------------------+--------------------------------------
//  req_     | in        | push / full                 | op, pixel_value (req_type)
//  rsp_     | out       | pop / empty                 | pixel_char and run/line/image flags
//  csr_     | in/out    | psel, penable, pwrite/pready| rows, cols, range, magnification
//
//  a load beat is written into the store as it is taken, loads go back to back while req_full is low
//  an emit beat is registered in the front stage; the back then scales it in its scale, offset
//  and prep states, divides out a 6-bit quotient for the 40 levels and sends the character
//  once per unit of magnification, as the rsp_ side takes it; transparent and floor pixels skip the divider
//  up to two emit beats plus one in the front stage wait while the back works
//  a stalled rsp_ side backs up the queue and then raises req_full
//  reset is synchronous and clears the walk, min/max, the queue and the output stage

module minmax_false_color_quantizer (
   input  wire logic               clock,
   input  wire logic               reset,
   // input channel
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire mmfcq_pkg::req_type req_data,
   // result channel
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output mmfcq_pkg::rsp_type      rsp_data,
   // register port
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   logic [mmfcq_pkg::DIM_CFG_W-1:0]   rows_ff, rows_in;
   logic [mmfcq_pkg::DIM_CFG_W-1:0]   cols_ff, cols_in;
   logic [mmfcq_pkg::RANGE_CFG_W-1:0] range_ff, range_in;
   logic [mmfcq_pkg::MAG_CFG_W-1:0]   mag_ff, mag_in;

   logic                     csr_write;
   mmfcq_pkg::reg_index_type reg_index;
   mmfcq_pkg::cfg_type       cfg;

   // front to queue
   logic                fq_push, fq_full;
   mmfcq_pkg::cmd_type  fq_data;
   // queue to back
   logic                qb_pop, qb_empty;
   mmfcq_pkg::cmd_type  qb_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = mmfcq_pkg::reg_index_type'(csr_paddr[3:2]);

   // raw register values are kept, clamping happens on use
   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      range_in = range_ff;
      mag_in   = mag_ff;
      if (csr_write) begin
         unique case (reg_index)
            mmfcq_pkg::REG_ROWS:  rows_in  = csr_pwdata[mmfcq_pkg::DIM_CFG_W-1:0];
            mmfcq_pkg::REG_COLS:  cols_in  = csr_pwdata[mmfcq_pkg::DIM_CFG_W-1:0];
            mmfcq_pkg::REG_RANGE: range_in = csr_pwdata[mmfcq_pkg::RANGE_CFG_W-1:0];
            mmfcq_pkg::REG_MAG:   mag_in   = csr_pwdata[mmfcq_pkg::MAG_CFG_W-1:0];
            default:              rows_in  = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mmfcq_pkg::DIM_CFG_W'(mmfcq_pkg::MAX_ROWS);
         cols_ff  <= mmfcq_pkg::DIM_CFG_W'(mmfcq_pkg::MAX_COLS);
         range_ff <= mmfcq_pkg::RANGE_CFG_W'(mmfcq_pkg::PCT_FULL);
         mag_ff   <= mmfcq_pkg::MAG_CFG_W'(1);
      end else begin
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         range_ff <= range_in;
         mag_ff   <= mag_in;
      end
   end

   // register readback
   always_comb begin
      unique case (reg_index)
         mmfcq_pkg::REG_ROWS:  csr_prdata = 32'(rows_ff);
         mmfcq_pkg::REG_COLS:  csr_prdata = 32'(cols_ff);
         mmfcq_pkg::REG_RANGE: csr_prdata = 32'(range_ff);
         mmfcq_pkg::REG_MAG:   csr_prdata = 32'(mag_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // clamped settings for both halves
   assign cfg = '{rows:      mmfcq_pkg::clamp_dim(rows_ff,
                                mmfcq_pkg::DIM_CFG_W'(mmfcq_pkg::MAX_ROWS)),
                  cols:      mmfcq_pkg::clamp_dim(cols_ff,
                                mmfcq_pkg::DIM_CFG_W'(mmfcq_pkg::MAX_COLS)),
                  range_pct: mmfcq_pkg::clamp_range(range_ff),
                  mag:       mmfcq_pkg::clamp_mag(mag_ff)};

   // loads, min/max and display walk
   mmfcq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg),
      .q_push   (fq_push),
      .q_data   (fq_data),
      .q_full   (fq_full)
   );

   // decouples front stalls from back stalls
   mmfcq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .full      (fq_full),
      .push_data (fq_data),
      .pop       (qb_pop),
      .empty     (qb_empty),
      .pop_data  (qb_data)
   );

   // scaling, level divider and beat replication
   mmfcq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (qb_empty),
      .q_data    (qb_data),
      .q_pop     (qb_pop),
      .cfg       (cfg),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: dv/tb_minmax_false_color_quantizer.sv
// self-checking testbench for the min/max false color quantizer: loads, emits and register sweeps
`timescale 1ns / 1ps

// mirror of the image store and display walk, plus the queue of characters still owed
class quantizer_scoreboard;
   logic [6:0]         rows_reg, cols_reg, range_reg;
   logic [3:0]         mag_reg;
   logic signed [23:0] pixels [mmfcq_pkg::STORE_DEPTH];
   logic signed [23:0] max_seen, min_seen;
   int                 load_count, src_row, row_rep, src_col;
   bit                 emitting;
   mmfcq_pkg::rsp_type owed_chars[$];
   int                 mismatches, checked_beats;

   function new();
      rows_reg      = 7'd64;
      cols_reg      = 7'd64;
      range_reg     = 7'd100;
      mag_reg       = 4'd1;
      mismatches    = 0;
      checked_beats = 0;
      restart();
   endfunction

   // back to the loading phase after the last character of an image
   function void restart();
      max_seen   = '0;
      min_seen   = '0;
      load_count = 0;
      emitting   = 0;
      src_row    = 0;
      row_rep    = 0;
      src_col    = 0;
   endfunction

   function void write_reg(mmfcq_pkg::reg_index_type idx, logic [31:0] value);
      case (idx)
         mmfcq_pkg::REG_ROWS:  rows_reg  = value[6:0];
         mmfcq_pkg::REG_COLS:  cols_reg  = value[6:0];
         mmfcq_pkg::REG_RANGE: range_reg = value[6:0];
         mmfcq_pkg::REG_MAG:   mag_reg   = value[3:0];
         default: ;
      endcase
   endfunction

   function int eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > mmfcq_pkg::MAX_ROWS) return mmfcq_pkg::MAX_ROWS;
      return int'(rows_reg);
   endfunction

   function int eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > mmfcq_pkg::MAX_COLS) return mmfcq_pkg::MAX_COLS;
      return int'(cols_reg);
   endfunction

   function int eff_mag();
      if (mag_reg == 0) return 1;
      if (mag_reg > mmfcq_pkg::MAX_MAG) return mmfcq_pkg::MAX_MAG;
      return int'(mag_reg);
   endfunction

   function int eff_range();
      if (range_reg > mmfcq_pkg::PCT_FULL) return mmfcq_pkg::PCT_FULL;
      return int'(range_reg);
   endfunction

   function int image_size();
      return eff_rows() * eff_cols();
   endfunction

   // true once emit beats produce characters
   function bit image_full();
      return emitting || (load_count >= image_size());
   endfunction

   // color level of one sample against the min/max of the loaded image
   function logic [7:0] char_for(logic signed [23:0] v);
      longint sample, hi, lo, top, num, den, q;
      sample = v;
      hi     = max_seen;
      lo     = min_seen;
      if (v == mmfcq_pkg::TRANSPARENT_CODE) return mmfcq_pkg::CHAR_TRANSPARENT;
      top = hi * eff_range();
      num = sample * 100;
      if (num > top) num = top;
      num = num - lo * 100;
      den = top - lo * 100;
      if (den <= 0) return mmfcq_pkg::CHAR_BASE;
      num = num * mmfcq_pkg::LEVELS;
      if (num < 0) q = 0;
      else q = num / den;
      if (q > mmfcq_pkg::LEVELS - 1) q = mmfcq_pkg::LEVELS - 1;
      return mmfcq_pkg::CHAR_BASE + 8'(q);
   endfunction

   // accepted input beat; returns 1 when it changed the state of the block
   function bit note_beat(mmfcq_pkg::req_type beat);
      int                 rows, cols, mag, idx, k;
      logic [7:0]         ch;
      bit                 eol, last_rep, last_row, eoi;
      mmfcq_pkg::rsp_type r;
      rows = eff_rows();
      cols = eff_cols();
      mag  = eff_mag();
      if (!emitting) begin
         if (load_count >= rows * cols) begin
            // image already complete after a shrink: a load is dropped
            emitting = 1;
            if (beat.op == mmfcq_pkg::OP_LOAD) return 1;
         end else begin
            if (beat.op != mmfcq_pkg::OP_LOAD) return 0;
            pixels[load_count] = beat.pixel_value;
            if (beat.pixel_value != mmfcq_pkg::TRANSPARENT_CODE) begin
               if (beat.pixel_value > max_seen) max_seen = beat.pixel_value;
               if (beat.pixel_value < min_seen) min_seen = beat.pixel_value;
            end
            load_count++;
            if (load_count >= rows * cols) emitting = 1;
            return 1;
         end
      end
      if (beat.op == mmfcq_pkg::OP_LOAD) return 0;

      idx      = src_row * cols + src_col;
      ch       = char_for(pixels[idx]);
      eol      = (src_col + 1 >= cols);
      last_rep = (row_rep + 1 >= mag);
      last_row = (src_row + 1 >= rows);
      eoi      = eol && last_rep && last_row;
      for (k = 0; k < mag; k++) begin
         r.pixel_char   = ch;
         r.last_of_run  = (k + 1 == mag);
         r.end_of_line  = (k + 1 == mag) && eol;
         r.end_of_image = (k + 1 == mag) && eoi;
         owed_chars.push_back(r);
      end

      if (eoi) begin
         restart();
      end else if (eol) begin
         src_col = 0;
         if (last_rep) begin
            row_rep = 0;
            src_row++;
         end else begin
            row_rep++;
         end
      end else begin
         src_col++;
      end
      return 1;
   endfunction

   function void check_beat(mmfcq_pkg::rsp_type got);
      mmfcq_pkg::rsp_type want;
      if (owed_chars.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected beat: char %0d run %0b line %0b image %0b", $time,
                     got.pixel_char, got.last_of_run, got.end_of_line, got.end_of_image);
         return;
      end
      want = owed_chars.pop_front();
      checked_beats++;
      if (got.pixel_char !== want.pixel_char || got.last_of_run !== want.last_of_run ||
          got.end_of_line !== want.end_of_line || got.end_of_image !== want.end_of_image) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: beat %0d expected char %0d run %0b line %0b image %0b, %s %0d %0b %0b %0b",
                     $time, checked_beats, want.pixel_char, want.last_of_run,
                     want.end_of_line, want.end_of_image, "got",
                     got.pixel_char, got.last_of_run, got.end_of_line, got.end_of_image);
      end
   endfunction
endclass

module tb_minmax_false_color_quantizer;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 6;
   localparam int ITEM_TARGET   = 360;
   // back stage: the scaling states, six divider steps and up to eight replicas,
   // so a load or an emit still in flight is done well within this
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 250;
   // slowest run: ~400 items, up to 8 beats each behind an 83% idle receiver,
   // the back stage work per emit and the register pauses, then several times over
   localparam int CYCLE_LIMIT   = 400000;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   mmfcq_pkg::req_type req_data;
   logic               rsp_empty;
   logic               rsp_pop;
   mmfcq_pkg::rsp_type rsp_data;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [3:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   quantizer_scoreboard image_sb = new();

   // idle percentages of the two sides, moved along as the run progresses
   int send_idle_pct = 17;
   int recv_idle_pct = 83;
   // long receiver hold-offs asked by the stimulus, served by the receiver
   int hold_requests = 0;
   int hold_served;
   int hold_left;
   bit pressure_done [3];

   int loads_taken  = 0;
   int emits_taken  = 0;
   int images_done  = 0;
   int random_base  = 0;
   int cycle_count  = 0;

   minmax_false_color_quantizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still owed", cycle_count,
                  image_sb.owed_chars.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random pop, or a long hold-off when the stimulus asks for one
   initial begin
      rsp_pop     = 1'b0;
      hold_left   = 0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_pop = 1'b0;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            rsp_pop   = 1'b0;
         end else begin
            rsp_pop = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // every popped beat is checked against the oldest owed character
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) image_sb.check_beat(rsp_data);
   end

   // which idling profile applies: receiver-starved, sender-starved, then none
   function automatic int idle_phase();
      int progress;
      progress = loads_taken + emits_taken - random_base;
      if (progress < ITEM_TARGET / 3) return 0;
      if (progress < 2 * ITEM_TARGET / 3) return 1;
      return 2;
   endfunction

   // offer one beat until the block takes it; the sender idles at random meanwhile
   task automatic send_beat(input logic op, input logic signed [23:0] value);
      mmfcq_pkg::req_type beat;
      bit                 taken;
      beat.op          = op;
      beat.pixel_value = value;
      taken            = 1'b0;
      case (idle_phase())
         0: begin
            send_idle_pct = 17;
            recv_idle_pct = 83;
         end
         1: begin
            send_idle_pct = 83;
            recv_idle_pct = 17;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
      while (!taken) begin
         @(negedge clock);
         if ($urandom_range(99) < send_idle_pct) begin
            req_push             = 1'b0;
            req_data.op          = 1'($urandom);
            req_data.pixel_value = 24'($urandom);
         end else begin
            req_push = 1'b1;
            req_data = beat;
         end
         @(posedge clock);
         taken = req_push && !req_full;
      end
      if (image_sb.note_beat(beat)) begin
         if (op == mmfcq_pkg::OP_LOAD) loads_taken++;
         else emits_taken++;
      end
   endtask

   // stop offering, wait until every owed beat is out, then let the back stage drain
   task automatic settle();
      @(negedge clock);
      req_push = 1'b0;
      while (image_sb.owed_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup cycle, access cycle, written on the edge where pready is seen
   task automatic csr_write(input mmfcq_pkg::reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = 4'(int'(idx) * 4);
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      image_sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // sample mix: transparent code and its neighbors, full-scale ends, small and wide values
   function automatic logic signed [23:0] rand_pixel();
      case ($urandom_range(11))
         0, 1:    return mmfcq_pkg::TRANSPARENT_CODE;
         2:       return mmfcq_pkg::TRANSPARENT_CODE + 24'sd1;
         3:       return mmfcq_pkg::TRANSPARENT_CODE - 24'sd1;
         4:       return 24'sh7FFFFF;
         5:       return 24'sh800000;
         6:       return '0;
         7, 8:    return 24'(int'($urandom_range(2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   // shrink only, so the walk never reaches a store entry this image did not load
   task automatic reshape_while_emitting();
      int rows_now, cols_now;
      settle();
      rows_now = image_sb.eff_rows();
      cols_now = image_sb.eff_cols();
      csr_write(mmfcq_pkg::REG_MAG, $urandom_range(15, 0));
      csr_write(mmfcq_pkg::REG_RANGE, $urandom_range(127, 0));
      if ($urandom_range(1)) csr_write(mmfcq_pkg::REG_COLS, $urandom_range(cols_now, 1));
      if ($urandom_range(1)) csr_write(mmfcq_pkg::REG_ROWS, $urandom_range(rows_now, 1));
   endtask

   // emit until the image is done; a few stray loads and size changes on the way
   task automatic run_emission();
      int pick;
      while (image_sb.image_full()) begin
         pick = $urandom_range(99);
         if (pick < 6) send_beat(mmfcq_pkg::OP_LOAD, rand_pixel());
         else if (pick < 9) reshape_while_emitting();
         else send_beat(mmfcq_pkg::OP_EMIT, rand_pixel());
      end
   endtask

   // one random image: settings, loads with stray emits, sometimes a cut, then the display
   task automatic run_image();
      int rows_raw, cols_raw, mag_raw, range_raw, cut, lim, pick;
      bit wide;
      settle();
      pick = $urandom_range(24);
      wide = (pick < 2);
      if (pick == 0) begin
         // tallest image, one column; 127 saturates to the maximum
         rows_raw = $urandom_range(1) ? 64 : 127;
         cols_raw = $urandom_range(1, 0);
      end else if (pick == 1) begin
         rows_raw = $urandom_range(1, 0);
         cols_raw = $urandom_range(1) ? 64 : 127;
      end else begin
         // mostly tiny images, zero saturates to one
         rows_raw = $urandom_range(5, 0);
         cols_raw = $urandom_range(5, 0);
      end
      pick = $urandom_range(9);
      if (wide) mag_raw = $urandom_range(2, 0);
      else if (pick == 0) mag_raw = 0;
      else if (pick == 1) mag_raw = 8;
      else if (pick == 2) mag_raw = $urandom_range(15, 9);
      else mag_raw = $urandom_range(3, 1);
      pick = $urandom_range(9);
      if (pick < 2) range_raw = 0;
      else if (pick < 4) range_raw = 100;
      else if (pick == 4) range_raw = $urandom_range(127, 101);
      else range_raw = $urandom_range(100, 1);
      csr_write(mmfcq_pkg::REG_ROWS, rows_raw);
      csr_write(mmfcq_pkg::REG_COLS, cols_raw);
      csr_write(mmfcq_pkg::REG_RANGE, range_raw);
      csr_write(mmfcq_pkg::REG_MAG, mag_raw);

      // broken sequence: the image shrinks below what is already loaded
      cut = image_sb.image_size();
      if (cut > 1 && $urandom_range(6) == 0) cut = $urandom_range(cut - 1, 1);
      while (image_sb.load_count < cut) begin
         if ($urandom_range(9) == 0) send_beat(mmfcq_pkg::OP_EMIT, rand_pixel());
         else send_beat(mmfcq_pkg::OP_LOAD, rand_pixel());
      end
      if (!image_sb.image_full()) begin
         settle();
         lim = (cut < mmfcq_pkg::MAX_COLS) ? cut : mmfcq_pkg::MAX_COLS;
         csr_write(mmfcq_pkg::REG_ROWS, 1);
         csr_write(mmfcq_pkg::REG_COLS, $urandom_range(lim, 1));
         // a load into the full image is dropped and starts the display
         if ($urandom_range(1)) send_beat(mmfcq_pkg::OP_LOAD, rand_pixel());
      end

      // back-pressure: receiver stops for a long stretch while emits keep coming,
      // enough pixels to fill the output, the back, the queue and the front stage
      if (!pressure_done[idle_phase()] && image_sb.image_size() >= 6) begin
         pressure_done[idle_phase()] = 1'b1;
         hold_requests++;
      end
      run_emission();
      images_done++;
   endtask

   initial begin
      reset       = 1'b1;
      req_push    = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // full-scale ends and a transparent pixel, each shown twice
      csr_write(mmfcq_pkg::REG_ROWS, 1);
      csr_write(mmfcq_pkg::REG_COLS, 3);
      csr_write(mmfcq_pkg::REG_RANGE, 100);
      csr_write(mmfcq_pkg::REG_MAG, 2);
      send_beat(mmfcq_pkg::OP_EMIT, '0);      // nothing loaded yet, ignored
      send_beat(mmfcq_pkg::OP_LOAD, 24'sh7FFFFF);
      send_beat(mmfcq_pkg::OP_LOAD, 24'sh800000);
      send_beat(mmfcq_pkg::OP_LOAD, mmfcq_pkg::TRANSPARENT_CODE);
      repeat (3) send_beat(mmfcq_pkg::OP_EMIT, '0);
      settle();

      // zero range: top of range and denominator collapse to zero
      csr_write(mmfcq_pkg::REG_ROWS, 2);
      csr_write(mmfcq_pkg::REG_COLS, 1);
      csr_write(mmfcq_pkg::REG_RANGE, 0);
      csr_write(mmfcq_pkg::REG_MAG, 1);
      send_beat(mmfcq_pkg::OP_LOAD, '0);
      send_beat(mmfcq_pkg::OP_LOAD, 24'sd5);
      repeat (2) send_beat(mmfcq_pkg::OP_EMIT, '0);
      settle();

      // saturating range and magnification, then shrink so the first emit starts the display
      csr_write(mmfcq_pkg::REG_ROWS, 2);
      csr_write(mmfcq_pkg::REG_COLS, 2);
      csr_write(mmfcq_pkg::REG_RANGE, 127);
      csr_write(mmfcq_pkg::REG_MAG, 0);
      send_beat(mmfcq_pkg::OP_LOAD, -24'sd7);
      send_beat(mmfcq_pkg::OP_LOAD, 24'sd300);
      send_beat(mmfcq_pkg::OP_LOAD, mmfcq_pkg::TRANSPARENT_CODE - 24'sd1);
      settle();
      csr_write(mmfcq_pkg::REG_COLS, 1);
      repeat (2) send_beat(mmfcq_pkg::OP_EMIT, '0);
      settle();

      // load into a shrunk image, load while emitting, column count cut mid display
      csr_write(mmfcq_pkg::REG_COLS, 2);
      csr_write(mmfcq_pkg::REG_MAG, 15);
      send_beat(mmfcq_pkg::OP_LOAD, 24'sd1000);
      send_beat(mmfcq_pkg::OP_LOAD, -24'sd1000);
      send_beat(mmfcq_pkg::OP_LOAD, mmfcq_pkg::TRANSPARENT_CODE);
      settle();
      csr_write(mmfcq_pkg::REG_ROWS, 1);
      send_beat(mmfcq_pkg::OP_LOAD, 24'sd12345);   // dropped, display starts
      send_beat(mmfcq_pkg::OP_LOAD, 24'sd12345);   // ignored while emitting
      send_beat(mmfcq_pkg::OP_EMIT, '0);
      settle();
      csr_write(mmfcq_pkg::REG_COLS, 1);
      csr_write(mmfcq_pkg::REG_MAG, 1);
      send_beat(mmfcq_pkg::OP_EMIT, '0);           // column past the new width ends the image

      // random images until enough beats have done something
      random_base = loads_taken + emits_taken;
      while (loads_taken + emits_taken < random_base + ITEM_TARGET) run_image();

      settle();
      $display("run: %0d pixel loads, %0d display requests, %0d random images, %0d beats checked",
               loads_taken, emits_taken, images_done, image_sb.checked_beats);
      $display("run: %0d long receiver hold-offs, %0d mismatches, %0d beats still owed",
               hold_served, image_sb.mismatches, image_sb.owed_chars.size());
      if (image_sb.mismatches == 0 && image_sb.owed_chars.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
